// ----- hw/rtl/dual_screen_color_compositor_macros.svh -----
// assertion macros used by the checker file of the compositor
// no dependencies; expects clk and rst_n in the including scope
`ifndef DUAL_SCREEN_COLOR_COMPOSITOR_MACROS_SVH
`define DUAL_SCREEN_COLOR_COMPOSITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define DSCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compositor check failed");

// next-cycle implication, disabled during reset
`define DSCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("compositor check failed");

`endif

// ----- hw/rtl/dscc_pkg.sv -----
// shared types, codes and sizes of the dual screen color compositor
// no dependencies
package dscc_pkg;

    localparam int PAL_DEPTH   = 256;
    localparam int QUEUE_DEPTH = 2;   // power of two
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // request codes
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_DISPLAY_MODE    = 3'd0;
    localparam logic [2:0] CFG_BLEND_SUBTRACT  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_A_ENABLE = 3'd2;
    localparam logic [2:0] CFG_SCREEN_B_ENABLE = 3'd3;
    localparam logic [2:0] CFG_B_BACKDROP_ONLY = 3'd4;
    localparam logic [2:0] CFG_BACKDROP_A      = 3'd5;
    localparam logic [2:0] CFG_BACKDROP_B      = 3'd6;

    // display modes; the two remaining codes show black
    localparam logic [2:0] MODE_BLEND      = 3'd0;
    localparam logic [2:0] MODE_HALF_BLEND = 3'd1;
    localparam logic [2:0] MODE_A_ONLY     = 3'd2;
    localparam logic [2:0] MODE_AVERAGE    = 3'd3;
    localparam logic [2:0] MODE_B_OVER_A   = 3'd4;
    localparam logic [2:0] MODE_A_OVER_B   = 3'd5;

    // rgb555 channel positions
    localparam int RED_LSB   = 10;
    localparam int GREEN_LSB = 5;
    localparam int BLUE_LSB  = 0;
    localparam logic [4:0] CH_MAX = 5'h1F;

    typedef struct packed {
        logic [2:0]  display_mode;
        logic        blend_subtract;
        logic        screen_a_enable;
        logic        screen_b_enable;
        logic        b_backdrop_only;
        logic [15:0] backdrop_a;
        logic [15:0] backdrop_b;
    } cfg_t;

    typedef struct packed {
        logic        nz_a;
        logic        nz_b;
        logic [15:0] pal_a;
        logic [15:0] pal_b;
    } queue_entry_t;

endpackage

// ----- hw/rtl/dscc_front.sv -----
// front end: accepts requests, owns the palette ram, reads both pixel colors
// depends on dscc_pkg
module dscc_front
    import dscc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         op,
    input  logic [7:0]   index_a,
    input  logic [7:0]   index_b,
    input  logic [7:0]   pal_addr,
    input  logic [15:0]  pal_data,
    output queue_entry_t push_data,
    output logic         push_valid,
    input  logic         push_ready
);

    logic [15:0] palette_mem [PAL_DEPTH];
    logic [15:0] rd_a_reg;
    logic [15:0] rd_b_reg;
    logic        nz_a_reg;
    logic        nz_b_reg;
    logic        valid_reg;
    logic        valid_next;
    logic        accept;
    logic        pix_accept;
    logic        pal_write;

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign pix_accept = accept && (op == OP_PIXEL);
    assign pal_write  = accept && (op == OP_PAL_WRITE);

    // read stage advances whenever a new request can be taken
    assign valid_next = in_ready ? pix_accept : valid_reg;

    always_ff @(posedge clk)
    begin
        if (pal_write)
        begin
            palette_mem[pal_addr] <= pal_data;
        end
        if (pix_accept)
        begin
            rd_a_reg <= palette_mem[index_a];
            rd_b_reg <= palette_mem[index_b];
            nz_a_reg <= (index_a != 8'd0);
            nz_b_reg <= (index_b != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_data  = '{nz_a: nz_a_reg, nz_b: nz_b_reg, pal_a: rd_a_reg, pal_b: rd_b_reg};

endmodule

// ----- hw/rtl/dscc_queue.sv -----
// short queue of classified pixels between the front and back ends
// depends on dscc_pkg
module dscc_queue
    import dscc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  queue_entry_t push_data,
    input  logic         push_valid,
    output logic         push_ready,
    output queue_entry_t pop_data,
    output logic         pop_valid,
    input  logic         pop_ready
);

    queue_entry_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/dscc_back.sv -----
// back end: resolves screen colors, composites the display color, output register
// depends on dscc_pkg
module dscc_back
    import dscc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  queue_entry_t pop_data,
    input  logic         pop_valid,
    output logic         pop_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [15:0]  display_color,
    output logic [15:0]  screen_a_color,
    output logic [15:0]  screen_b_color
);

    function automatic logic [4:0] blend_chan(input logic [4:0] a, input logic [4:0] b,
                                              input logic sub, input logic halve);
        logic signed [6:0] v;
        logic [4:0]        r;
        v = sub ? $signed({2'b00, a}) - $signed({2'b00, b})
                : $signed({2'b00, a}) + $signed({2'b00, b});
        if (halve)
        begin
            v = v >>> 1;   // floor for negative differences
        end
        if (v < 0)
        begin
            r = 5'd0;
        end
        else if (v > $signed({2'b00, CH_MAX}))
        begin
            r = CH_MAX;
        end
        else
        begin
            r = v[4:0];
        end
        return r;
    endfunction

    function automatic logic [4:0] avg_chan(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[5:1];
    endfunction

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] display_reg;
    logic [15:0] col_a_reg;
    logic [15:0] col_b_reg;
    logic [15:0] col_a;
    logic [15:0] col_b;
    logic [15:0] in_a;
    logic [15:0] in_b;
    logic [15:0] disp;
    logic        b_from_pal;
    logic        take;
    logic        halve;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        b_from_pal = pop_data.nz_b && !cfg.b_backdrop_only;
        col_a      = pop_data.nz_a ? pop_data.pal_a : cfg.backdrop_a;
        col_b      = b_from_pal ? pop_data.pal_b : cfg.backdrop_b;
        in_a       = cfg.screen_a_enable ? col_a : 16'd0;
        in_b       = cfg.screen_b_enable ? col_b : 16'd0;
        halve      = (cfg.display_mode == MODE_HALF_BLEND);
        case (cfg.display_mode)
            MODE_BLEND, MODE_HALF_BLEND:
            begin
                disp = {1'b0,
                        blend_chan(in_a[RED_LSB+:5], in_b[RED_LSB+:5],
                                   cfg.blend_subtract, halve),
                        blend_chan(in_a[GREEN_LSB+:5], in_b[GREEN_LSB+:5],
                                   cfg.blend_subtract, halve),
                        blend_chan(in_a[BLUE_LSB+:5], in_b[BLUE_LSB+:5],
                                   cfg.blend_subtract, halve)};
            end
            MODE_A_ONLY:
            begin
                disp = in_a;
            end
            MODE_AVERAGE:
            begin
                disp = {1'b0,
                        avg_chan(in_a[RED_LSB+:5], in_b[RED_LSB+:5]),
                        avg_chan(in_a[GREEN_LSB+:5], in_b[GREEN_LSB+:5]),
                        avg_chan(in_a[BLUE_LSB+:5], in_b[BLUE_LSB+:5])};
            end
            MODE_B_OVER_A:
            begin
                disp = (cfg.screen_b_enable && b_from_pal) ? col_b : in_a;
            end
            MODE_A_OVER_B:
            begin
                disp = (cfg.screen_a_enable && pop_data.nz_a) ? col_a : in_b;
            end
            default:
            begin
                disp = 16'd0;
            end
        endcase
    end

    assign out_valid_next = pop_ready ? pop_valid : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            display_reg <= disp;
            col_a_reg   <= col_a;
            col_b_reg   <= col_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign display_color  = display_reg;
    assign screen_a_color = col_a_reg;
    assign screen_b_color = col_b_reg;

endmodule

// ----- hw/rtl/dual_screen_color_compositor.sv -----
// a pixel result passes the front read register, the queue and the output register,
// and waits longer while the output is stalled; palette writes give no result
// throughput: one request per cycle while the queue has room, set by the palette ram (two read ports, one write)
// reset: control state and all configuration registers clear; palette contents are kept
// top level of the dual screen color compositor: configuration registers, front, queue, back
// depends on dscc_pkg, dscc_front, dscc_queue, dscc_back
module dual_screen_color_compositor
    import dscc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  index_a,
    input  logic [7:0]  index_b,
    input  logic [7:0]  pal_addr,
    input  logic [15:0] pal_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] display_color,
    output logic [15:0] screen_a_color,
    output logic [15:0] screen_b_color,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    queue_entry_t push_data;
    queue_entry_t pop_data;
    logic         push_valid;
    logic         push_ready;
    logic         pop_valid;
    logic         pop_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DISPLAY_MODE:    cfg_next.display_mode    = cfg_data[2:0];
                CFG_BLEND_SUBTRACT:  cfg_next.blend_subtract  = cfg_data[0];
                CFG_SCREEN_A_ENABLE: cfg_next.screen_a_enable = cfg_data[0];
                CFG_SCREEN_B_ENABLE: cfg_next.screen_b_enable = cfg_data[0];
                CFG_B_BACKDROP_ONLY: cfg_next.b_backdrop_only = cfg_data[0];
                CFG_BACKDROP_A:      cfg_next.backdrop_a      = cfg_data;
                CFG_BACKDROP_B:      cfg_next.backdrop_b      = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dscc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .index_a    (index_a),
        .index_b    (index_b),
        .pal_addr   (pal_addr),
        .pal_data   (pal_data),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dscc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    dscc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .pop_data       (pop_data),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .display_color  (display_color),
        .screen_a_color (screen_a_color),
        .screen_b_color (screen_b_color)
    );

endmodule

// ----- hw/rtl/dscc_checker.sv -----
// port-level checks of the compositor, bound to the top level
// depends on dual_screen_color_compositor_macros.svh
`include "dual_screen_color_compositor_macros.svh"

module dscc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] display_color,
    input logic [15:0] screen_a_color,
    input logic [15:0] screen_b_color,
    input logic        cfg_ready
);

    // a stalled result holds its payload
    `DSCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(display_color) && $stable(screen_a_color)
            && $stable(screen_b_color))

    // input backpressure only while a result is waiting at the output
    `DSCC_ASSERT_NOW(a_in_stall_cause, !in_ready, out_valid)

    // configuration writes are never refused
    `DSCC_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready)

endmodule

bind dual_screen_color_compositor dscc_checker u_dscc_checker (.*);
